### src/mrpt_pkg.sv
package mrpt_pkg;

    // Width of the candidate and of every residue handled by the datapath.
    localparam int NUM_WIDTH = 62;
    // Number of small primes used both for trial division and as witnesses.
    localparam int NUM_BASES = 9;
    // Width of one small prime.
    localparam int BASE_W = 5;
    // Counter width for bit positions and for the power of two in n - 1.
    localparam int STEP_W = $clog2(NUM_WIDTH);
    // Index width for the prime table.
    localparam int IDX_W = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;

    localparam logic [BASE_W-1:0] PRIME_TAB [0:8] = '{
        5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23
    };

    // Outcome of the small-prime screen.
    typedef struct packed {
        logic decided;
        logic verdict;
    } screen_t;

endpackage

### src/mrpt_trial_div.sv
// Bit-serial remainders of the candidate by every small prime, most
// significant bit first, one bit per cycle for all primes in parallel.
module mrpt_trial_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mrpt_pkg::NUM_WIDTH-1:0] n,
    output logic                           done,
    output mrpt_pkg::screen_t              screen
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [mrpt_pkg::STEP_W-1:0]     cnt_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0]  sh_reg;
    logic [mrpt_pkg::BASE_W-1:0]     rem_reg  [mrpt_pkg::NUM_BASES];
    logic [mrpt_pkg::BASE_W-1:0]     rem_next [mrpt_pkg::NUM_BASES];
    logic [mrpt_pkg::BASE_W:0]       rem_wide [mrpt_pkg::NUM_BASES];
    logic                            div_any;
    logic                            eq_any;
    logic                            below_last;

    // The shifted remainder stays below twice the prime, so one
    // conditional subtract brings it back into range.
    always_comb
    begin
        for (int i = 0; i < mrpt_pkg::NUM_BASES; i++)
        begin
            rem_wide[i] = {rem_reg[i], sh_reg[mrpt_pkg::NUM_WIDTH-1]};
            if (rem_wide[i] >= {1'b0, mrpt_pkg::PRIME_TAB[i]})
            begin
                rem_next[i] = mrpt_pkg::BASE_W'(rem_wide[i] - {1'b0, mrpt_pkg::PRIME_TAB[i]});
            end
            else
            begin
                rem_next[i] = rem_wide[i][mrpt_pkg::BASE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            sh_reg   <= '0;
            for (int i = 0; i < mrpt_pkg::NUM_BASES; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= mrpt_pkg::STEP_W'(mrpt_pkg::NUM_WIDTH - 1);
                sh_reg   <= n;
                for (int i = 0; i < mrpt_pkg::NUM_BASES; i++)
                begin
                    rem_reg[i] <= '0;
                end
            end
            else if (busy_reg)
            begin
                sh_reg <= {sh_reg[mrpt_pkg::NUM_WIDTH-2:0], 1'b0};
                for (int i = 0; i < mrpt_pkg::NUM_BASES; i++)
                begin
                    rem_reg[i] <= rem_next[i];
                end
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg  <= cnt_reg - 1'b1;
                    done_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    // A candidate divisible by a small prime is prime only when it is that
    // prime; anything else below the largest prime is composite.
    always_comb
    begin
        div_any = 1'b0;
        eq_any  = 1'b0;
        for (int i = 0; i < mrpt_pkg::NUM_BASES; i++)
        begin
            if (rem_reg[i] == '0)
            begin
                div_any = 1'b1;
            end
            if (n == mrpt_pkg::NUM_WIDTH'(mrpt_pkg::PRIME_TAB[i]))
            begin
                eq_any = 1'b1;
            end
        end
        below_last = n < mrpt_pkg::NUM_WIDTH'(mrpt_pkg::PRIME_TAB[mrpt_pkg::NUM_BASES-1]);
    end

    assign done           = done_reg;
    assign screen.decided = div_any || below_last;
    assign screen.verdict = div_any && eq_any;

endmodule

### src/mrpt_mulmod.sv
// Shift-and-add modular multiply, one multiplier bit per cycle, least
// significant bit first. Both operands must already be below the modulus.
module mrpt_mulmod
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mrpt_pkg::NUM_WIDTH-1:0] a,
    input  logic [mrpt_pkg::NUM_WIDTH-1:0] b,
    input  logic [mrpt_pkg::NUM_WIDTH-1:0] m,
    output logic                           done,
    output logic [mrpt_pkg::NUM_WIDTH-1:0] product
);

    logic                           busy_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] acc_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] x_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] y_reg;
    logic [mrpt_pkg::NUM_WIDTH:0]   sum;
    logic [mrpt_pkg::NUM_WIDTH:0]   dbl;
    logic [mrpt_pkg::NUM_WIDTH-1:0] acc_next;
    logic [mrpt_pkg::NUM_WIDTH-1:0] x_next;

    always_comb
    begin
        sum = {1'b0, acc_reg} + (y_reg[0] ? {1'b0, x_reg} : '0);
        if (sum >= {1'b0, m})
        begin
            acc_next = mrpt_pkg::NUM_WIDTH'(sum - {1'b0, m});
        end
        else
        begin
            acc_next = sum[mrpt_pkg::NUM_WIDTH-1:0];
        end

        dbl = {x_reg, 1'b0};
        if (dbl >= {1'b0, m})
        begin
            x_next = mrpt_pkg::NUM_WIDTH'(dbl - {1'b0, m});
        end
        else
        begin
            x_next = dbl[mrpt_pkg::NUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            acc_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            acc_reg  <= '0;
            x_reg    <= a;
            y_reg    <= b;
        end
        else if (busy_reg)
        begin
            if (y_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
                x_reg   <= x_next;
                y_reg   <= {1'b0, y_reg[mrpt_pkg::NUM_WIDTH-1:1]};
            end
        end
    end

    assign done    = busy_reg && (y_reg == '0);
    assign product = acc_reg;

endmodule

### src/miller_rabin_primality_test.sv
// Channel   Signals                       Direction  Meaning
// input     in_valid, in_stall, candidate  in         one candidate per transfer
// output    out_valid, out_stall, is_prime out        one verdict per candidate
//
// Flow: one candidate at a time. The trial division runs first; then the
// power of two is extracted from n - 1. Each witness round then runs about
// popcount(t) + bitlen(t) + s modular multiplies in the bit-serial
// multiply unit, which sets the pace; small or screened-out candidates
// finish far sooner than wide candidates that run every round.
// Reset: rst_n is asynchronous and active low; it empties the block and
// the output register. Stalls: a finished verdict waits in the output
// register while the next candidate is already accepted and worked on.
module miller_rabin_primality_test
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mrpt_pkg::NUM_WIDTH-1:0] candidate,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           is_prime
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_SPLIT,
        ST_BASE_INIT,
        ST_EXP_STEP,
        ST_EXP_MUL_WAIT,
        ST_EXP_SQR_WAIT,
        ST_CHECK,
        ST_SQ_CHECK,
        ST_SQ_WAIT,
        ST_NEXT_BASE,
        ST_FINISH
    } state_t;

    state_t                         state_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] n_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] nm1_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] t_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] e_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] acc_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] b_reg;
    logic [mrpt_pkg::STEP_W-1:0]    s_reg;
    logic [mrpt_pkg::STEP_W-1:0]    j_reg;
    logic [mrpt_pkg::IDX_W-1:0]     idx_reg;
    logic                           verdict_reg;
    logic                           trial_start_reg;
    logic                           mul_start_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] mul_a_reg;
    logic [mrpt_pkg::NUM_WIDTH-1:0] mul_b_reg;
    logic                           out_valid_reg;
    logic                           is_prime_reg;

    logic                           trial_done;
    mrpt_pkg::screen_t              screen;
    logic                           mul_done;
    logic [mrpt_pkg::NUM_WIDTH-1:0] mul_product;
    logic                           trial_issue;
    logic                           sq_more;
    logic                           mul_issue;

    mrpt_trial_div u_trial_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (trial_start_reg),
        .n      (n_reg),
        .done   (trial_done),
        .screen (screen)
    );

    mrpt_mulmod u_mulmod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .m       (n_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // Start pulses for the two serial units, registered so they rise in the cycle
    // after the state that launches them.
    always_comb
    begin
        trial_issue = (state_reg == ST_IDLE) && in_valid;
        sq_more     = ({1'b0, j_reg} + 1'b1) < {1'b0, s_reg};
        mul_issue   = ((state_reg == ST_EXP_STEP) && (e_reg != '0))
                   || ((state_reg == ST_SQ_CHECK) && (acc_reg != nm1_reg) && sq_more);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            n_reg           <= '0;
            nm1_reg         <= '0;
            t_reg           <= '0;
            e_reg           <= '0;
            acc_reg         <= '0;
            b_reg           <= '0;
            s_reg           <= '0;
            j_reg           <= '0;
            idx_reg         <= '0;
            verdict_reg     <= 1'b0;
            trial_start_reg <= 1'b0;
            mul_start_reg   <= 1'b0;
            mul_a_reg       <= '0;
            mul_b_reg       <= '0;
            out_valid_reg   <= 1'b0;
            is_prime_reg    <= 1'b0;
        end
        else
        begin
            trial_start_reg <= trial_issue;
            mul_start_reg   <= mul_issue;

            // The waiting verdict leaves on its transfer; in the finishing
            // state the new verdict takes its place in the same cycle.
            if (out_valid_reg && !out_stall && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        n_reg     <= candidate;
                        state_reg <= ST_SCREEN;
                    end
                end

                // Small primes settle even numbers, multiples and tiny values.
                ST_SCREEN:
                begin
                    if (trial_done)
                    begin
                        if (screen.decided)
                        begin
                            verdict_reg <= screen.verdict;
                            state_reg   <= ST_FINISH;
                        end
                        else
                        begin
                            nm1_reg   <= n_reg - 1'b1;
                            t_reg     <= n_reg - 1'b1;
                            s_reg     <= '0;
                            state_reg <= ST_SPLIT;
                        end
                    end
                end

                // n - 1 is even and nonzero here, so the shift ends.
                ST_SPLIT:
                begin
                    if (!t_reg[0])
                    begin
                        t_reg <= {1'b0, t_reg[mrpt_pkg::NUM_WIDTH-1:1]};
                        s_reg <= s_reg + 1'b1;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_BASE_INIT;
                    end
                end

                // Every base is below the candidate, which exceeds the
                // largest small prime after the screen.
                ST_BASE_INIT:
                begin
                    acc_reg   <= mrpt_pkg::NUM_WIDTH'(1);
                    b_reg     <= mrpt_pkg::NUM_WIDTH'(mrpt_pkg::PRIME_TAB[idx_reg]);
                    e_reg     <= t_reg;
                    state_reg <= ST_EXP_STEP;
                end

                // Square-and-multiply over the exponent, low bit first. A set
                // bit is first used for a multiply and then cleared, so the
                // next visit squares and shifts.
                ST_EXP_STEP:
                begin
                    if (e_reg == '0)
                    begin
                        state_reg <= ST_CHECK;
                    end
                    else if (e_reg[0])
                    begin
                        mul_a_reg <= acc_reg;
                        mul_b_reg <= b_reg;
                        state_reg <= ST_EXP_MUL_WAIT;
                    end
                    else
                    begin
                        mul_a_reg <= b_reg;
                        mul_b_reg <= b_reg;
                        state_reg <= ST_EXP_SQR_WAIT;
                    end
                end

                ST_EXP_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= mul_product;
                        e_reg     <= {e_reg[mrpt_pkg::NUM_WIDTH-1:1], 1'b0};
                        state_reg <= ST_EXP_STEP;
                    end
                end

                ST_EXP_SQR_WAIT:
                begin
                    if (mul_done)
                    begin
                        b_reg     <= mul_product;
                        e_reg     <= {1'b0, e_reg[mrpt_pkg::NUM_WIDTH-1:1]};
                        state_reg <= ST_EXP_STEP;
                    end
                end

                ST_CHECK:
                begin
                    j_reg <= '0;
                    if (acc_reg == mrpt_pkg::NUM_WIDTH'(1))
                    begin
                        state_reg <= ST_NEXT_BASE;
                    end
                    else
                    begin
                        state_reg <= ST_SQ_CHECK;
                    end
                end

                // Look for n - 1 among x, x^2, ..., x^(2^(s-1)).
                ST_SQ_CHECK:
                begin
                    if (acc_reg == nm1_reg)
                    begin
                        state_reg <= ST_NEXT_BASE;
                    end
                    else if (sq_more)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        mul_a_reg <= acc_reg;
                        mul_b_reg <= acc_reg;
                        state_reg <= ST_SQ_WAIT;
                    end
                    else
                    begin
                        verdict_reg <= 1'b0;
                        state_reg   <= ST_FINISH;
                    end
                end

                ST_SQ_WAIT:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= mul_product;
                        state_reg <= ST_SQ_CHECK;
                    end
                end

                ST_NEXT_BASE:
                begin
                    if (idx_reg == mrpt_pkg::IDX_W'(mrpt_pkg::NUM_BASES - 1))
                    begin
                        verdict_reg <= 1'b1;
                        state_reg   <= ST_FINISH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_BASE_INIT;
                    end
                end

                // Hand the verdict to the output register once it is free.
                ST_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        is_prime_reg  <= verdict_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule

### tb/mrpt_checker.sv
module mrpt_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [mrpt_pkg::NUM_WIDTH-1:0] candidate,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           is_prime,
    output int                             failures,
    output int                             pending
);

    typedef struct {
        logic [mrpt_pkg::NUM_WIDTH-1:0] number;
        logic                           verdict;
    } verdict_rec_t;

    verdict_rec_t owed_verdicts[$];

    // (a * b) mod m, one bit of b per pass, the way the hardware does it.
    function automatic logic [63:0] mulmod_shift_add(logic [63:0] a, logic [63:0] b,
                                                     logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd0;
        a = a % m;
        b = b % m;
        while (b != 64'd0)
        begin
            if (b[0])
            begin
                acc = acc + a;
                if (acc >= m)
                    acc = acc - m;
            end
            b = b >> 1;
            a = a << 1;
            if (a >= m)
                a = a - m;
        end
        return acc;
    endfunction

    function automatic logic [63:0] powmod_square_multiply(logic [63:0] b, logic [63:0] e,
                                                           logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        b = b % m;
        while (e != 64'd0)
        begin
            if (e[0])
                acc = mulmod_shift_add(acc, b, m);
            e = e >> 1;
            b = mulmod_shift_add(b, b, m);
        end
        return acc;
    endfunction

    function automatic logic primality_verdict(logic [63:0] n);
        logic [63:0] p;
        logic [63:0] t;
        logic [63:0] x;
        int          s;
        logic        passed;
        for (int i = 0; i < mrpt_pkg::NUM_BASES; i++)
        begin
            p = 64'(mrpt_pkg::PRIME_TAB[i]);
            if (n % p == 64'd0)
                return (n == p);
        end
        if (n < 64'(mrpt_pkg::PRIME_TAB[mrpt_pkg::NUM_BASES-1]))
            return 1'b0;
        t = n - 64'd1;
        s = 0;
        while (!t[0])
        begin
            t = t >> 1;
            s++;
        end
        for (int i = 0; i < mrpt_pkg::NUM_BASES; i++)
        begin
            x = powmod_square_multiply(64'(mrpt_pkg::PRIME_TAB[i]), t, n);
            if (x != 64'd1)
            begin
                passed = 1'b0;
                for (int j = 0; j < s && !passed; j++)
                begin
                    if (x == n - 64'd1)
                        passed = 1'b1;
                    x = mulmod_shift_add(x, x, n);
                end
                if (!passed)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Outputs are retired before the new candidate is queued: a verdict leaving at
    // the same edge can never belong to the candidate that enters there.
    always @(posedge clk)
    begin : watch
        verdict_rec_t head;
        verdict_rec_t fresh;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_verdicts.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected verdict %0b with no candidate waiting", is_prime);
                    failures <= failures + 1;
                end
                else
                begin
                    head = owed_verdicts.pop_front();
                    if (is_prime !== head.verdict)
                    begin
                        if (failures < 10)
                            $display("verdict mismatch for %0d: expected %0b, got %0b",
                                     head.number, head.verdict, is_prime);
                        failures <= failures + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                fresh.number  = candidate;
                fresh.verdict = primality_verdict(64'(candidate));
                owed_verdicts.push_back(fresh);
            end
            pending <= owed_verdicts.size();
        end
    end

endmodule

### tb/tb.sv
module tb;

    localparam int NW = mrpt_pkg::NUM_WIDTH;
    // The slowest legal candidate runs every witness round with no transfer on
    // either channel, so the watchdog limit leaves ample room for it.
    localparam int QUIET_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 100;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [NW-1:0] candidate = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          is_prime;

    int            failures;
    int            pending;
    int            quiet_cycles = 0;
    // While set, neither side inserts idle cycles.
    logic          steady = 1'b0;

    always #5 clk = ~clk;

    miller_rabin_primality_test dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    // The checker watches both channels, predicts each verdict and compares.
    mrpt_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime),
        .failures  (failures),
        .pending   (pending)
    );

    // The result side refuses transfers at random with a chance of about 22 percent,
    // except during the steady stretch.
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(99) < 22);

    // The watchdog ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // True when one of the small primes divides n, i.e. the block decides it in
    // the screening pass and never reaches the witness rounds.
    function automatic logic has_small_factor(logic [63:0] n);
        for (int i = 0; i < mrpt_pkg::NUM_BASES; i++)
            if (n % 64'(mrpt_pkg::PRIME_TAB[i]) == 64'd0)
                return 1'b1;
        return 1'b0;
    endfunction

    // A candidate below 2^bits, with bits drawn from 2 to 20. Small sizes keep the
    // witness rounds short, as the multiply unit steps through the multiplier bits.
    // With rough set, the draw is made odd and retried until no small prime divides
    // it (at most 40 tries), so it usually runs every strong-probable-prime round.
    function automatic logic [NW-1:0] small_candidate(bit rough);
        int          bits;
        int          tries;
        logic [63:0] v;
        bits  = $urandom_range(20, 2);
        tries = 0;
        do
        begin
            v = {$urandom, $urandom} & ((64'd1 << bits) - 64'd1);
            if (rough)
                v[0] = 1'b1;
            tries++;
        end
        while (rough && has_small_factor(v) && tries < 40);
        return NW'(v);
    endfunction

    // Present one candidate and hold it until the block takes it. Inputs change only
    // at falling edges, and the acceptance is seen at the rising edge, before the
    // block updates its stall. The task returns at the falling edge after the
    // transfer, so the next call can keep valid high with a single assignment.
    task automatic send_candidate(logic [NW-1:0] n);
        while (!steady && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [NW-1:0] directed_set [$];
        logic [NW-1:0] v;
        int            sel;
        int            p;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: zero and one, every small prime, small composites and
        // squares, a Carmichael number, a strong pseudoprime to the first four
        // bases, the all-ones candidate, a Mersenne prime, the largest prime below
        // the range limit, the square of a large prime, and the smallest strong
        // pseudoprime to all nine bases, which the rounds report as prime.
        directed_set = '{62'd0, 62'd1, 62'd2, 62'd3, 62'd4, 62'd5, 62'd7, 62'd9,
                         62'd11, 62'd13, 62'd17, 62'd19, 62'd23, 62'd25, 62'd29,
                         62'd31, 62'd561, 62'd3215031751,
                         62'd4611686018427387903, 62'd2305843009213693952,
                         62'd2305843009213693951, 62'd4611686018427387847,
                         62'd4611686014132420609, 62'd3825123056546413051};
        foreach (directed_set[i])
            send_candidate(directed_set[i]);

        // Random part. Most candidates are small; five in eight of those are drawn free of
        // small factors so that they run every witness round. Wide candidates are mostly
        // forced to carry a small factor, which keeps them cheap while still
        // toggling every bit; a rare few are only made odd and may run the full rounds.
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            steady = (k >= 40 && k < 65);
            sel = $urandom_range(99);
            if (sel < 50)
                v = small_candidate(1'b1);
            else if (sel < 80)
                v = small_candidate(1'b0);
            else if (sel < 97)
            begin
                v = NW'({$urandom, $urandom});
                p = mrpt_pkg::PRIME_TAB[$urandom_range(mrpt_pkg::NUM_BASES - 1)];
                v = v - NW'(v % NW'(p));
            end
            else
                v = NW'({$urandom, $urandom}) | NW'(1);
            send_candidate(v);
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Wait for every verdict to come out, then give the block time to show any
        // stray extra output.
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### files.f
src/mrpt_pkg.sv
src/mrpt_trial_div.sv
src/mrpt_mulmod.sv
src/miller_rabin_primality_test.sv
tb/mrpt_checker.sv
tb/tb.sv
